// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
package lkv_pkg;

	// Number of entry slots
	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int DATA_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [AGE_W-1:0] age_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CAP_W-1:0] cap_t;
	typedef logic signed [DATA_W-1:0] word_t;

	// Action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// Capacity after reset
	localparam cap_t CAP_RESET = cap_t'(16);

	// Value returned on a get miss
	localparam word_t MISS_VALUE = '1;

	typedef struct packed {
		logic  action;
		word_t key;
		word_t value;
	} req_t;

	typedef struct packed {
		logic  found;
		word_t read_value;
	} rsp_t;

	// Search results over the entry table
	typedef struct packed {
		logic hit;
		idx_t hit_idx;
		logic fill;
		idx_t free_idx;
		idx_t old_idx;
	} lookup_t;

endpackage

// ===== design/lkv_lookup.sv =====
// Parallel key match, free slot and oldest entry search over the table.
module lkv_lookup (
	input  lkv_pkg::word_t   key,
	input  lkv_pkg::cap_t    cap,
	input  lkv_pkg::word_t   entry_key [lkv_pkg::ENTRIES],
	input  logic [lkv_pkg::ENTRIES-1:0] entry_valid,
	input  lkv_pkg::age_t    entry_age [lkv_pkg::ENTRIES],
	input  lkv_pkg::cnt_t    count,
	output lkv_pkg::lookup_t result
);

	lkv_pkg::cnt_t eff_cap;
	lkv_pkg::cnt_t oldest_age;

	// Clamp capacity to 1 .. ENTRIES
	always_comb begin
		if (cap == '0) begin
			eff_cap = lkv_pkg::cnt_t'(1);
		end else if (int'(cap) > lkv_pkg::ENTRIES) begin
			eff_cap = lkv_pkg::cnt_t'(lkv_pkg::ENTRIES);
		end else begin
			eff_cap = lkv_pkg::cnt_t'(cap);
		end
	end

	// Valid ages form 0 .. count-1, so the oldest holds count-1
	assign oldest_age = count - lkv_pkg::cnt_t'(1);

	// Priority encoders: scan high to low so the lowest slot wins
	always_comb begin
		result = '0;
		for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (entry_valid[i] && entry_key[i] == key) begin
				result.hit     = 1'b1;
				result.hit_idx = lkv_pkg::idx_t'(i);
			end
			if (!entry_valid[i]) begin
				result.free_idx = lkv_pkg::idx_t'(i);
			end
			if (entry_valid[i] && lkv_pkg::cnt_t'(entry_age[i]) == oldest_age) begin
				result.old_idx = lkv_pkg::idx_t'(i);
			end
		end
		result.fill = (count < eff_cap);
	end

endmodule

// ===== design/lkv_table.sv =====
// Entry table: keys, data, valid bits, ages and fill count, with LRU update.
module lkv_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          upd_en,
	input  lkv_pkg::req_t req,
	input  lkv_pkg::cap_t cap,
	output lkv_pkg::rsp_t rsp
);

	lkv_pkg::word_t   key_q   [lkv_pkg::ENTRIES];
	lkv_pkg::word_t   data_q  [lkv_pkg::ENTRIES];
	logic [lkv_pkg::ENTRIES-1:0] valid_q;
	lkv_pkg::age_t    age_q   [lkv_pkg::ENTRIES];
	lkv_pkg::cnt_t    count_q;

	lkv_pkg::lookup_t lk;
	logic             is_put;
	logic             do_fill;
	logic             do_touch;
	lkv_pkg::idx_t    tgt;
	lkv_pkg::cnt_t    thresh;

	lkv_lookup u_lookup (
		.key         (req.key),
		.cap         (cap),
		.entry_key   (key_q),
		.entry_valid (valid_q),
		.entry_age   (age_q),
		.count       (count_q),
		.result      (lk)
	);

	// Pick the target slot and the age threshold below which entries grow older
	always_comb begin
		is_put   = (req.action == lkv_pkg::ACT_PUT);
		do_fill  = is_put && !lk.hit && lk.fill;
		do_touch = lk.hit || is_put;
		if (lk.hit) begin
			tgt = lk.hit_idx;
		end else if (do_fill) begin
			tgt = lk.free_idx;
		end else begin
			tgt = lk.old_idx;
		end
		// a fill ages every valid entry; otherwise those younger than the target
		thresh = do_fill ? count_q : lkv_pkg::cnt_t'(age_q[tgt]);
	end

	// Get response
	always_comb begin
		rsp.found      = lk.hit;
		rsp.read_value = lk.hit ? data_q[lk.hit_idx] : lkv_pkg::MISS_VALUE;
	end

	// Control state: valid bits, ages, fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else if (upd_en && do_touch) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (lkv_pkg::idx_t'(i) == tgt) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && lkv_pkg::cnt_t'(age_q[i]) < thresh) begin
					age_q[i] <= lkv_pkg::age_t'(age_q[i] + 1'b1);
				end
			end
			if (is_put) begin
				valid_q[tgt] <= 1'b1;
			end
			if (do_fill) begin
				count_q <= count_q + lkv_pkg::cnt_t'(1);
			end
		end
	end

	// Payload: key and data written on put
	always_ff @(posedge clk) begin
		if (upd_en && is_put) begin
			key_q[tgt]  <= req.key;
			data_q[tgt] <= req.value;
		end
	end

endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the LRU key/value cache: input stage, table and result register.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req  (action, key, value)
//   rsp     | out       | rsp_valid / rsp_stall | rsp  (found, read_value)
//   cfg     | in        | cfg_wr_en             | cfg_wr_data (capacity_in_use)
//
// One item per cycle while the input stage is not stalled. In the input stage,
// all entries compare in parallel and the ages update; a get's result is
// registered and shows the cycle after it leaves. Puts give no result.
// Reset clears valid bits, ages and fill count; capacity returns to 16.
// A get waits in the input stage only while the result register is full and
// stalled; puts pass regardless.
module lru_key_value_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lkv_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lkv_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  lkv_pkg::cap_t cfg_wr_data
);

	logic          valid_s1;
	lkv_pkg::req_t req_s1;
	logic          rsp_valid_q;
	lkv_pkg::rsp_t rsp_q;
	lkv_pkg::cap_t cap_q;
	lkv_pkg::rsp_t tbl_rsp;
	logic          is_get_s1;
	logic          go_s1;

	// A get may move on only when the result register can take it
	assign is_get_s1 = (req_s1.action == lkv_pkg::ACT_GET);
	assign go_s1     = !(is_get_s1 && rsp_valid_q && rsp_stall);
	assign req_stall = valid_s1 && !go_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	lkv_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (valid_s1 && go_s1),
		.req    (req_s1),
		.cap    (cap_q),
		.rsp    (tbl_rsp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (valid_s1 && go_s1 && is_get_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && go_s1 && is_get_s1) begin
			rsp_q <= tbl_rsp;
		end
	end

endmodule

// ===== design/lkv_checker.sv =====
// Port-level checks for the LRU key/value cache, bound to the top level.
module lkv_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input lkv_pkg::rsp_t rsp
);

	// A stalled result stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result dropped or changed while stalled");

	// A miss always reads as all ones
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.read_value == lkv_pkg::MISS_VALUE)
		else $error("miss result not -1");

	// The input side backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without output backpressure");

	// A new result follows an item accepted into the input stage and passed on
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
		else $error("result appeared without an accepted item");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

// ===== dv/lkv_checker.sv =====
// Scoreboard for the LRU key/value cache: tracks the table, predicts get results, compares.
module lkv_scoreboard (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  lkv_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  lkv_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  lkv_pkg::cap_t cfg_wr_data,
	output int            fail_count,
	output int            outstanding
);

	// Shadow copy of the entry table
	lkv_pkg::word_t slot_key  [lkv_pkg::ENTRIES];
	lkv_pkg::word_t slot_data [lkv_pkg::ENTRIES];
	logic           slot_live [lkv_pkg::ENTRIES];
	int             slot_age  [lkv_pkg::ENTRIES];
	int             live_count;
	lkv_pkg::cap_t  capacity;

	// Get results still owed by the cache, oldest first
	lkv_pkg::rsp_t  pending_lookups [$];
	int    errors = 0;
	int    lookups_seen = 0;

	assign fail_count = errors;

	function automatic void flag(string msg);
		errors++;
		if (errors <= 10)
			$display("lookup %0d: %s", lookups_seen, msg);
	endfunction

	// Capacity zero acts as one; anything above the table size saturates
	function automatic int cap_limit();
		int c;
		c = int'(capacity);
		if (c == 0)
			c = 1;
		if (c > lkv_pkg::ENTRIES)
			c = lkv_pkg::ENTRIES;
		return c;
	endfunction

	function automatic int find_slot(lkv_pkg::word_t k);
		int i;
		for (i = 0; i < lkv_pkg::ENTRIES; i++)
			if (slot_live[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	// Slot s becomes most recent; live entries younger than it move back one
	function automatic void promote(int s);
		int i;
		int a;
		a = slot_age[s];
		for (i = 0; i < lkv_pkg::ENTRIES; i++)
			if (slot_live[i] && i != s && slot_age[i] < a)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	function automatic int lru_slot();
		int i;
		int best;
		int best_age;
		best = 0;
		best_age = -1;
		for (i = 0; i < lkv_pkg::ENTRIES; i++) begin
			if (slot_live[i] && slot_age[i] > best_age) begin
				best = i;
				best_age = slot_age[i];
			end
		end
		return best;
	endfunction

	// Apply one accepted item to the shadow table; gets queue their result
	function automatic void access_table(lkv_pkg::req_t item);
		int            s;
		int            i;
		lkv_pkg::rsp_t want;
		s = find_slot(item.key);
		if (item.action == lkv_pkg::ACT_GET) begin
			if (s >= 0) begin
				want.found = 1'b1;
				want.read_value = slot_data[s];
				promote(s);
			end else begin
				want.found = 1'b0;
				want.read_value = lkv_pkg::MISS_VALUE;
			end
			pending_lookups.push_back(want);
			return;
		end
		// put to a present key: update in place
		if (s >= 0) begin
			slot_data[s] = item.value;
			promote(s);
			return;
		end
		// put to an absent key: lowest free slot while under capacity
		if (live_count < cap_limit()) begin
			for (i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (!slot_live[i]) begin
					for (int j = 0; j < lkv_pkg::ENTRIES; j++)
						if (slot_live[j])
							slot_age[j]++;
					slot_live[i] = 1'b1;
					slot_key[i] = item.key;
					slot_data[i] = item.value;
					slot_age[i] = 0;
					live_count++;
					return;
				end
			end
		end
		// otherwise replace the least recent entry
		s = lru_slot();
		slot_key[s] = item.key;
		slot_data[s] = item.value;
		slot_live[s] = 1'b1;
		promote(s);
	endfunction

	function automatic void check_lookup(lkv_pkg::rsp_t got);
		lkv_pkg::rsp_t want;
		lookups_seen++;
		if (pending_lookups.size() == 0) begin
			flag($sformatf("unexpected result found=%0b read_value=%h",
				got.found, got.read_value));
			return;
		end
		want = pending_lookups.pop_front();
		if (got.found !== want.found)
			flag($sformatf("found expected %0b, got %0b", want.found, got.found));
		if (got.read_value !== want.read_value)
			flag($sformatf("read_value expected %h, got %h",
				want.read_value, got.read_value));
	endfunction

	// Results are checked before the same edge's request: a get never answers at once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				slot_live[i] = 1'b0;
				slot_age[i] = 0;
			end
			live_count = 0;
			capacity = lkv_pkg::CAP_RESET;
			pending_lookups.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_lookup(rsp);
			if (req_valid && !req_stall)
				access_table(req);
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			outstanding <= pending_lookups.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the LRU key/value cache: clock, reset, stimulus, watchdog and verdict.
module tb;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int SEGMENTS = 12;
	localparam int SEGMENT_ITEMS = 104;
	localparam lkv_pkg::word_t KEY_MIN = lkv_pkg::word_t'(32'h8000_0000);
	localparam lkv_pkg::word_t KEY_MAX = lkv_pkg::word_t'(32'h7FFF_FFFF);
	localparam lkv_pkg::word_t ALL_ONES = lkv_pkg::word_t'(32'hFFFF_FFFF);

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	lkv_pkg::req_t  req;
	logic           rsp_valid;
	logic           rsp_stall;
	lkv_pkg::rsp_t  rsp;
	logic           cfg_wr_en;
	lkv_pkg::cap_t  cfg_wr_data;

	int             fail_count;
	int             outstanding;
	int             send_idle_pct;
	int             recv_idle_pct;
	lkv_pkg::word_t key_pool [$];

	lru_key_value_cache dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	lkv_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Result side back-pressure
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Ends the run when nothing moves on either channel for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// One item, with random idle cycles before it; returns at the accepting edge
	task automatic send_req(input logic action, input lkv_pkg::word_t key,
		input lkv_pkg::word_t value);
		lkv_pkg::req_t item;
		item.action = action;
		item.key = key;
		item.value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Stop sending, wait for every owed result, then let a trailing put settle
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input lkv_pkg::cap_t cap);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic lkv_pkg::word_t pick_key();
		if (key_pool.size() != 0 && $urandom_range(99) < 85)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return lkv_pkg::word_t'($urandom);
	endfunction

	initial begin : stimulus
		lkv_pkg::cap_t caps [SEGMENTS];
		int            seg;
		int            eff;

		caps = '{lkv_pkg::cap_t'(16), lkv_pkg::cap_t'(1), lkv_pkg::cap_t'(31),
			lkv_pkg::cap_t'(2), lkv_pkg::cap_t'(0), lkv_pkg::cap_t'(8),
			lkv_pkg::cap_t'(17), lkv_pkg::cap_t'(5), lkv_pkg::cap_t'(16),
			lkv_pkg::cap_t'(3), lkv_pkg::cap_t'(15), lkv_pkg::cap_t'(1)};
		caps[SEGMENTS-1] = lkv_pkg::cap_t'($urandom_range(1, 31));

		send_idle_pct = 8;
		recv_idle_pct = 64;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes at reset capacity: miss on empty, fills, hits, update, final miss
		send_req(lkv_pkg::ACT_GET, '0, '0);
		send_req(lkv_pkg::ACT_PUT, KEY_MIN, KEY_MAX);
		send_req(lkv_pkg::ACT_PUT, KEY_MAX, KEY_MIN);
		send_req(lkv_pkg::ACT_PUT, '0, '0);
		send_req(lkv_pkg::ACT_PUT, ALL_ONES, ALL_ONES);
		send_req(lkv_pkg::ACT_GET, KEY_MIN, '0);
		send_req(lkv_pkg::ACT_GET, KEY_MAX, '0);
		send_req(lkv_pkg::ACT_GET, '0, '0);
		send_req(lkv_pkg::ACT_GET, ALL_ONES, '0);
		send_req(lkv_pkg::ACT_PUT, KEY_MAX, lkv_pkg::word_t'(32'h5A5A_A5A5));
		send_req(lkv_pkg::ACT_GET, KEY_MAX, ALL_ONES);
		send_req(lkv_pkg::ACT_GET, lkv_pkg::word_t'(1), KEY_MIN);
		drain();

		// Capacity zero behaves as one, and is below the live count
		write_capacity(lkv_pkg::cap_t'(0));
		send_req(lkv_pkg::ACT_PUT, lkv_pkg::word_t'(7), lkv_pkg::word_t'(70));
		send_req(lkv_pkg::ACT_GET, KEY_MIN, '0);
		send_req(lkv_pkg::ACT_GET, lkv_pkg::word_t'(7), '0);
		send_req(lkv_pkg::ACT_PUT, lkv_pkg::word_t'(8), lkv_pkg::word_t'(80));
		send_req(lkv_pkg::ACT_GET, '0, '0);
		send_req(lkv_pkg::ACT_GET, lkv_pkg::word_t'(8), '0);
		drain();

		// Oversized capacity saturates at the table size
		write_capacity(lkv_pkg::cap_t'(31));
		for (int k = 20; k < 34; k++)
			send_req(lkv_pkg::ACT_PUT, lkv_pkg::word_t'(k), lkv_pkg::word_t'(k * 3));
		send_req(lkv_pkg::ACT_GET, lkv_pkg::word_t'(20), '0);
		send_req(lkv_pkg::ACT_GET, ALL_ONES, '0);
		drain();

		// Random segments: key pools slightly larger than the capacity give hits,
		// refreshes and evictions; stray keys mostly miss
		for (seg = 0; seg < SEGMENTS; seg++) begin
			send_idle_pct = (seg < 4) ? 8 : ((seg < 8) ? 64 : 0);
			recv_idle_pct = (seg < 4) ? 64 : ((seg < 8) ? 8 : 0);
			write_capacity(caps[seg]);
			eff = (caps[seg] == 0) ? 1 :
				((caps[seg] > lkv_pkg::ENTRIES) ? lkv_pkg::ENTRIES : int'(caps[seg]));
			key_pool.delete();
			repeat (eff + $urandom_range(1, 6))
				key_pool.push_back(lkv_pkg::word_t'($urandom));
			if ($urandom_range(3) == 0)
				key_pool.push_back(KEY_MIN);
			if ($urandom_range(3) == 0)
				key_pool.push_back(ALL_ONES);
			repeat (SEGMENT_ITEMS) begin
				send_req(($urandom_range(99) < 45) ? lkv_pkg::ACT_PUT : lkv_pkg::ACT_GET,
					pick_key(), lkv_pkg::word_t'($urandom));
			end
			drain();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
